// ===== sv/lru_key_value_cache_assert.svh =====
// ---------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Concurrent check macros for the cache; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define LKVC_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) else $error(msg);
// Check prop at every rising edge, reset included.
`define LKVC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define LKVC_ASSERT(lbl, ck, rstn, prop, msg)
`define LKVC_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// ===== sv/lkvc_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU key/value cache package
// Shared widths, command codes and the lookup status type.
// ---------------------------------------------------------------------------
package lkvc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Summary of one associative lookup
  typedef struct packed {
    logic hit;       // key present in a valid entry
    logic free_any;  // at least one entry not in use
    logic lru_any;   // a valid entry holds the oldest rank
  } match_stat_t;

endpackage

// ===== sv/lru_key_value_cache.sv =====
// ---------------------------------------------------------------------------
// LRU key/value cache
// Fully associative get/put cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
//
//  channel | ports                                         | beat
//  --------+-----------------------------------------------+---------------------
//  in      | in_valid in_stall in_command in_key in_value  | one get or put
//  out     | out_valid out_stall out_hit out_read_value    | one result per get
//  cfg     | cfg_wen cfg_wdata                             | capacity_in_use write
//
//  An input beat lands in the stage register; the lookup, rank update and
//  write-back then complete from the stage register into the contents and
//  the result register, and a new beat is taken every cycle unless the
//  input is stalled. The rate is set by the single-pass compare and rank
//  update across all entries. Reset clears the valid marks and the fill
//  count and sets the limit to 16. A get waits in the stage register only
//  while the result register is full and stalled; puts never wait.
//
module lru_key_value_cache #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic signed [lkvc_pkg::DATA_W-1:0] out_read_value,
  input  logic                               cfg_wen,
  input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata
);

`include "lru_key_value_cache_assert.svh"

  localparam int DW     = lkvc_pkg::DATA_W;
  localparam int CW     = lkvc_pkg::CAP_W;
  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USED_W = $clog2(CAPACITY + 1);
  localparam int LIM_W  = (USED_W > CW) ? USED_W : CW;

  // configuration
  logic [CW-1:0] cap_r;

  // stage register
  logic          stg_valid_r;
  logic          stg_cmd_r;
  logic [DW-1:0] stg_key_r;
  logic [DW-1:0] stg_value_r;

  // cache contents
  logic [DW-1:0]     keys_r   [CAPACITY];
  logic [DW-1:0]     values_r [CAPACITY];
  logic [RANK_W-1:0] ranks_r  [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;

  // result register
  logic          out_valid_r;
  logic          out_hit_r;
  logic [DW-1:0] out_value_r;

  // lookup
  logic [CAPACITY-1:0]   hit_oh, free_oh, lru_oh, tgt_oh;
  lkvc_pkg::match_stat_t stat;
  logic [RANK_W-1:0]     lru_rank;
  logic [RANK_W-1:0]     hit_rank;
  logic [DW-1:0]         hit_value;
  logic [LIM_W-1:0]      eff_lim;
  logic [USED_W-1:0]     old_rank;
  logic                  do_fill, do_evict, do_promote;
  logic                  out_free, stg_fire, in_take;
  logic [RANK_W-1:0]     ranks_nxt [CAPACITY];

  // ------------------------------------------------------------ handshake
  // A put always drains; a get needs room in the result register.
  assign out_free = !out_valid_r || !out_stall;
  assign stg_fire = stg_valid_r && ((stg_cmd_r == lkvc_pkg::CMD_PUT) || out_free);
  assign in_stall = stg_valid_r && !stg_fire;
  assign in_take  = in_valid && !in_stall;

  // ------------------------------------------------------------ lookup
  // The oldest valid entry always carries rank used-1.
  assign lru_rank = RANK_W'(used_r - 1'b1);

  lkvc_match #(
    .CAPACITY (CAPACITY),
    .RANK_W   (RANK_W)
  ) u_match (
    .key      (stg_key_r),
    .keys     (keys_r),
    .valid    (valid_r),
    .ranks    (ranks_r),
    .lru_rank (lru_rank),
    .hit_oh   (hit_oh),
    .free_oh  (free_oh),
    .lru_oh   (lru_oh),
    .stat     (stat)
  );

  // Gather rank and value of the hitting entry (at most one).
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_oh[i]) begin
        hit_rank  = hit_rank  | ranks_r[i];
        hit_value = hit_value | values_r[i];
      end
    end
  end

  // Limit of zero acts as one; above the entry count it saturates.
  always_comb begin
    if (cap_r == '0) begin
      eff_lim = LIM_W'(1);
    end else if (LIM_W'(cap_r) > LIM_W'(CAPACITY)) begin
      eff_lim = LIM_W'(CAPACITY);
    end else begin
      eff_lim = LIM_W'(cap_r);
    end
  end

  // ------------------------------------------------------------ update
  always_comb begin
    do_fill    = 1'b0;
    do_evict   = 1'b0;
    do_promote = 1'b0;
    tgt_oh     = '0;
    old_rank   = '0;
    valid_nxt  = valid_r;
    used_nxt   = used_r;

    if (stg_fire) begin
      if (stat.hit) begin
        // get hit or put update: refresh the hitting entry
        do_promote = 1'b1;
        tgt_oh     = hit_oh;
        old_rank   = USED_W'(hit_rank);
      end else if (stg_cmd_r == lkvc_pkg::CMD_PUT) begin
        if ((LIM_W'(used_r) < eff_lim) && stat.free_any) begin
          do_fill    = 1'b1;
          do_promote = 1'b1;
          tgt_oh     = free_oh;
          old_rank   = used_r;      // every valid entry ages
          valid_nxt  = valid_r | free_oh;
          used_nxt   = USED_W'(used_r + 1'b1);
        end else if (stat.lru_any) begin
          do_evict   = 1'b1;
          do_promote = 1'b1;
          tgt_oh     = lru_oh;
          old_rank   = USED_W'(lru_rank);
        end
      end
    end

    for (int i = 0; i < CAPACITY; i++) begin
      ranks_nxt[i] = ranks_r[i];
      if (do_promote) begin
        if (tgt_oh[i]) begin
          ranks_nxt[i] = '0;
        end else if (valid_r[i] && (USED_W'(ranks_r[i]) < old_rank)) begin
          ranks_nxt[i] = RANK_W'(ranks_r[i] + 1'b1);
        end
      end
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lkvc_pkg::CAP_RESET;
      stg_valid_r <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      // advance the stage when it drains, hold it otherwise
      if (in_take) begin
        stg_valid_r <= 1'b1;
      end else if (stg_fire) begin
        stg_valid_r <= 1'b0;
      end
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      if (stg_fire && (stg_cmd_r == lkvc_pkg::CMD_GET)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_cmd_r   <= in_command;
      stg_key_r   <= in_key;
      stg_value_r <= in_value;
    end
    if (stg_fire && (stg_cmd_r == lkvc_pkg::CMD_GET)) begin
      out_hit_r   <= stat.hit;
      out_value_r <= stat.hit ? hit_value : '0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      ranks_r[i] <= ranks_nxt[i];
      if (stg_fire && (stg_cmd_r == lkvc_pkg::CMD_PUT) && tgt_oh[i]) begin
        values_r[i] <= stg_value_r;
        if (do_fill || do_evict) begin
          keys_r[i] <= stg_key_r;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

  // ------------------------------------------------------------ checks
  `LKVC_ASSERT(a_used_matches_valid, clk, rst_n, $countones(valid_r) == used_r, "fill count differs from valid marks")
  `LKVC_ASSERT(a_used_in_range, clk, rst_n, used_r <= USED_W'(CAPACITY), "fill count above capacity")
  `LKVC_ASSERT(a_put_no_beat, clk, rst_n, (stg_fire && (stg_cmd_r == lkvc_pkg::CMD_PUT) && !(out_valid_r && out_stall)) |=> !out_valid_r, "put produced a result beat")
  `LKVC_ASSERT(a_stall_needs_stage, clk, rst_n, in_stall |-> (stg_valid_r && (stg_cmd_r == lkvc_pkg::CMD_GET) && out_valid_r && out_stall), "input stalled without a blocked get")

endmodule

// ===== sv/lkvc_match.sv =====
// ---------------------------------------------------------------------------
// LRU key/value cache lookup
// Parallel key compare, first free entry and oldest entry, as one-hot vectors.
// ---------------------------------------------------------------------------
module lkvc_match #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF,
  parameter int RANK_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic [lkvc_pkg::DATA_W-1:0] key,
  input  logic [lkvc_pkg::DATA_W-1:0] keys [CAPACITY],
  input  logic [CAPACITY-1:0]         valid,
  input  logic [RANK_W-1:0]           ranks [CAPACITY],
  input  logic [RANK_W-1:0]           lru_rank,
  output logic [CAPACITY-1:0]         hit_oh,
  output logic [CAPACITY-1:0]         free_oh,
  output logic [CAPACITY-1:0]         lru_oh,
  output lkvc_pkg::match_stat_t       stat
);

  logic [CAPACITY:0] free_seen;

  always_comb begin
    free_seen[0] = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_oh[i]       = valid[i] && (keys[i] == key);
      lru_oh[i]       = valid[i] && (ranks[i] == lru_rank);
      // first free entry wins
      free_oh[i]      = !valid[i] && !free_seen[i];
      free_seen[i+1]  = free_seen[i] || !valid[i];
    end
    stat.hit      = |hit_oh;
    stat.free_any = free_seen[CAPACITY];
    stat.lru_any  = |lru_oh;
  end

endmodule
